// ----- hw/rtl/htok_pkg.sv -----
// Shared types, character codes and helpers for the HTTP request tokenizer.
`default_nettype none

package htok_pkg;

    localparam int unsigned PARAM_LIMIT_DEF  = 8;
    localparam int unsigned HEADER_LIMIT_DEF = 16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_PATH   = 3'd1;
    localparam logic [2:0] CLS_PNAME  = 3'd2;
    localparam logic [2:0] CLS_PVALUE = 3'd3;
    localparam logic [2:0] CLS_HNAME  = 3'd4;
    localparam logic [2:0] CLS_HVALUE = 3'd5;

    localparam logic [2:0] ST_RUNNING     = 3'd0;
    localparam logic [2:0] ST_COMPLETE    = 3'd1;
    localparam logic [2:0] ST_BAD_METHOD  = 3'd2;
    localparam logic [2:0] ST_BAD_PATH    = 3'd3;
    localparam logic [2:0] ST_BAD_PARAMS  = 3'd4;
    localparam logic [2:0] ST_BAD_HEADERS = 3'd5;

    typedef enum logic [9:0] {
        PH_METHOD   = 10'b00_0000_0001,
        PH_PATH     = 10'b00_0000_0010,
        PH_PNAME    = 10'b00_0000_0100,
        PH_PVALUE   = 10'b00_0000_1000,
        PH_LINESKIP = 10'b00_0001_0000,
        PH_HNAME    = 10'b00_0010_0000,
        PH_HVALUE   = 10'b00_0100_0000,
        PH_HTAIL    = 10'b00_1000_0000,
        PH_DONE     = 10'b01_0000_0000,
        PH_ERROR    = 10'b10_0000_0000
    } t_phase;

    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h47;
            2'd1:    c = 8'h45;
            2'd2:    c = 8'h54;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/http_request_tokenizer.sv -----
// Top level of the HTTP request tokenizer: byte-serial request line and header parser.
`default_nettype none

// Takes one request byte per clock cycle while o_ready is high and returns one result
// per byte: the byte is decoded against the parse state in a single pass of logic and
// the result lands in the output register in the cycle after the byte is accepted. The
// output register lets a new byte be accepted in the same cycle that the previous result
// is taken, so the sustained rate is one byte per cycle whenever the sink is ready. A
// byte flagged as last ends the request and returns the parser to its reset state.
module http_request_tokenizer
    import htok_pkg::*;
#(
    parameter int unsigned PARAM_LIMIT  = PARAM_LIMIT_DEF,
    parameter int unsigned HEADER_LIMIT = HEADER_LIMIT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_last_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_field_class,
    output logic [7:0]      o_out_char,
    output logic [3:0]      o_item_number,
    output logic [7:0]      o_char_position,
    output logic [2:0]      o_parse_status,
    output logic            o_request_done
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_method_cnt, n_method_cnt;
    logic        r_method_ok, n_method_ok;
    logic [7:0]  r_held_char, n_held_char;
    logic        r_held_valid, n_held_valid;
    logic [7:0]  r_path_len, n_path_len;
    logic [4:0]  r_entry, n_entry;
    logic [7:0]  r_pos, n_pos;
    logic        r_skip, n_skip;
    logic [2:0]  r_final, n_final;

    logic        r_out_valid;
    logic [2:0]  r_cls;
    logic [7:0]  r_ch;
    logic [3:0]  r_item;
    logic [7:0]  r_opos;
    logic [2:0]  r_status;
    logic        r_done;

    logic [2:0]  n_cls;
    logic [7:0]  n_ch;
    logic [3:0]  n_item;
    logic [7:0]  n_opos;
    logic [2:0]  n_status;
    logic        n_done;
    logic        completed;
    logic        accept;
    logic [7:0]  b;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign b       = i_in_byte;

    always_comb begin
        n_phase      = r_phase;
        n_method_cnt = r_method_cnt;
        n_method_ok  = r_method_ok;
        n_held_char  = r_held_char;
        n_held_valid = r_held_valid;
        n_path_len   = r_path_len;
        n_entry      = r_entry;
        n_pos        = r_pos;
        n_skip       = r_skip;
        n_final      = r_final;
        n_cls        = CLS_NONE;
        n_ch         = 8'd0;
        n_item       = 4'd0;
        n_opos       = 8'd0;
        n_status     = ST_RUNNING;
        n_done       = 1'b0;
        completed    = 1'b0;

        case (r_phase)
            PH_METHOD: begin
                if (b == CH_SPACE) begin
                    if (r_method_ok) begin
                        n_phase      = PH_PATH;
                        n_pos        = 8'd0;
                        n_path_len   = 8'd0;
                        n_held_valid = 1'b0;
                    end else begin
                        n_phase = PH_ERROR;
                        n_final = ST_BAD_METHOD;
                    end
                end else if (!r_method_ok) begin
                    if (r_method_cnt != 2'd3 && b == get_char(r_method_cnt)) begin
                        n_method_cnt = r_method_cnt + 2'd1;
                        if (r_method_cnt == 2'd2) begin
                            n_method_ok = 1'b1;
                        end
                    end else begin
                        n_phase = PH_ERROR;
                        n_final = ST_BAD_METHOD;
                    end
                end
            end
            PH_PATH: begin
                if (b == CH_QUEST || b == CH_SPACE) begin
                    if (r_held_valid && !(r_held_char == CH_SLASH && r_path_len > 8'd1)) begin
                        n_cls  = CLS_PATH;
                        n_ch   = r_held_char;
                        n_opos = r_pos;
                    end
                    n_held_valid = 1'b0;
                    n_phase      = (b == CH_QUEST) ? PH_PNAME : PH_LINESKIP;
                    n_pos        = 8'd0;
                    n_entry      = 5'd0;
                end else begin
                    if (r_held_valid) begin
                        n_cls  = CLS_PATH;
                        n_ch   = r_held_char;
                        n_opos = r_pos;
                        n_pos  = sat_inc8(r_pos);
                    end
                    n_held_char  = b;
                    n_held_valid = 1'b1;
                    n_path_len   = sat_inc8(r_path_len);
                end
            end
            PH_PNAME: begin
                if (b == CH_EQUAL) begin
                    n_phase = PH_PVALUE;
                    n_pos   = 8'd0;
                end else begin
                    n_cls  = CLS_PNAME;
                    n_ch   = b;
                    n_item = r_entry[3:0];
                    n_opos = r_pos;
                    n_pos  = sat_inc8(r_pos);
                end
            end
            PH_PVALUE: begin
                if (b == CH_AMP) begin
                    n_entry = r_entry + 5'd1;
                    n_pos   = 8'd0;
                    n_phase = (n_entry >= 5'(PARAM_LIMIT)) ? PH_LINESKIP : PH_PNAME;
                end else if (b == CH_SPACE) begin
                    n_phase = PH_LINESKIP;
                end else begin
                    n_cls  = CLS_PVALUE;
                    n_ch   = b;
                    n_item = r_entry[3:0];
                    n_opos = r_pos;
                    n_pos  = sat_inc8(r_pos);
                end
            end
            PH_LINESKIP: begin
                if (b == CH_LF) begin
                    n_phase = PH_HNAME;
                    n_entry = 5'd0;
                    n_pos   = 8'd0;
                end
            end
            PH_HNAME: begin
                if (r_pos == 8'd0 && b == CH_LF) begin
                    completed = 1'b1;
                end else if (r_pos == 8'd0 && b == CH_CR) begin
                    n_phase = PH_HTAIL;
                end else if (b == CH_COLON) begin
                    n_phase = PH_HVALUE;
                    n_pos   = 8'd0;
                    n_skip  = 1'b1;
                end else begin
                    n_cls  = CLS_HNAME;
                    n_ch   = b;
                    n_item = r_entry[3:0];
                    n_opos = r_pos;
                    n_pos  = sat_inc8(r_pos);
                end
            end
            PH_HVALUE: begin
                if (b == CH_LF) begin
                    n_entry = r_entry + 5'd1;
                    n_pos   = 8'd0;
                    n_skip  = 1'b0;
                    n_phase = (n_entry >= 5'(HEADER_LIMIT)) ? PH_HTAIL : PH_HNAME;
                end else if (r_skip) begin
                    n_skip = 1'b0;
                end else begin
                    n_cls  = CLS_HVALUE;
                    n_ch   = b;
                    n_item = r_entry[3:0];
                    n_opos = r_pos;
                    n_pos  = sat_inc8(r_pos);
                end
            end
            PH_HTAIL: begin
                if (b == CH_LF) begin
                    completed = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (completed) begin
            n_phase  = PH_DONE;
            n_final  = ST_COMPLETE;
            n_status = ST_COMPLETE;
            n_done   = 1'b1;
        end else if (i_last_byte) begin
            case (n_phase)
                PH_METHOD: begin
                    n_status = ST_BAD_METHOD;
                    n_done   = 1'b1;
                end
                PH_PATH: begin
                    n_status = ST_BAD_PATH;
                    n_done   = 1'b1;
                end
                PH_PNAME, PH_PVALUE, PH_LINESKIP: begin
                    n_status = ST_BAD_PARAMS;
                    n_done   = 1'b1;
                end
                PH_HNAME, PH_HVALUE, PH_HTAIL: begin
                    n_status = ST_BAD_HEADERS;
                    n_done   = 1'b1;
                end
                PH_ERROR: begin
                    n_status = n_final;
                    n_done   = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last_byte)) begin
            r_phase      <= PH_METHOD;
            r_method_cnt <= 2'd0;
            r_method_ok  <= 1'b0;
            r_held_char  <= 8'd0;
            r_held_valid <= 1'b0;
            r_path_len   <= 8'd0;
            r_entry      <= 5'd0;
            r_pos        <= 8'd0;
            r_skip       <= 1'b0;
            r_final      <= ST_RUNNING;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_method_cnt <= n_method_cnt;
            r_method_ok  <= n_method_ok;
            r_held_char  <= n_held_char;
            r_held_valid <= n_held_valid;
            r_path_len   <= n_path_len;
            r_entry      <= n_entry;
            r_pos        <= n_pos;
            r_skip       <= n_skip;
            r_final      <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cls    <= n_cls;
            r_ch     <= n_ch;
            r_item   <= n_item;
            r_opos   <= n_opos;
            r_status <= n_status;
            r_done   <= n_done;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_field_class   = r_cls;
    assign o_out_char      = r_ch;
    assign o_item_number   = r_item;
    assign o_char_position = r_opos;
    assign o_parse_status  = r_status;
    assign o_request_done  = r_done;

    a_status_needs_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_RUNNING |-> r_done)
        else $error("nonzero status without request_done");

    a_none_is_blank : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_cls == CLS_NONE |-> r_ch == 8'd0 && r_opos == 8'd0)
        else $error("untagged result carries a byte or position");

    a_path_item_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_cls == CLS_PATH || r_cls == CLS_NONE) |-> r_item == 4'd0)
        else $error("path or untagged result carries an item number");

    a_last_resets : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_byte |=> r_phase == PH_METHOD && r_method_cnt == 2'd0
                                  && !r_held_valid && r_entry == 5'd0)
        else $error("parser not back at reset after last byte");

    a_done_phase : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_last_byte && n_status == ST_COMPLETE |=> r_phase == PH_DONE)
        else $error("completion without entering done phase");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the HTTP request tokenizer: directed table, then random requests.
module testbench;
    import htok_pkg::*;

    localparam int unsigned RANDOM_BYTES = 2000;
    localparam int unsigned STALL_LIMIT  = 500;
    localparam logic [7:0]  WORD_G       = "G";
    localparam logic [7:0]  WORD_E       = "E";
    localparam logic [7:0]  WORD_T       = "T";

    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] ch;
        logic [3:0] item;
        logic [7:0] pos;
        logic [2:0] status;
        logic       done;
    } t_token;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       typed;
        logic [2:0] status;
        logic       done;
    } t_table_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       i_last_byte;
    logic       o_valid;
    logic       i_ready;
    logic [2:0] o_field_class;
    logic [7:0] o_out_char;
    logic [3:0] o_item_number;
    logic [7:0] o_char_position;
    logic [2:0] o_parse_status;
    logic       o_request_done;

    t_token     expected_tokens[$];
    t_table_row directed_rows[$];
    logic [7:0] request_bytes[$];
    int         mismatches = 0;
    int         bytes_sent;
    int         stall_cycles = 0;
    logic       steady;

    t_phase     phase;
    logic [1:0] get_count;
    logic       get_seen;
    logic [7:0] held_char;
    logic       held_valid;
    logic [7:0] path_len;
    logic [4:0] entry_idx;
    logic [7:0] field_pos;
    logic       skip_pending;
    logic [2:0] error_status;

    http_request_tokenizer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_field_class   (o_field_class),
        .o_out_char      (o_out_char),
        .o_item_number   (o_item_number),
        .o_char_position (o_char_position),
        .o_parse_status  (o_parse_status),
        .o_request_done  (o_request_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [7:0] bump8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic void clear_parser();
        phase        = PH_METHOD;
        get_count    = 2'd0;
        get_seen     = 1'b0;
        held_char    = 8'd0;
        held_valid   = 1'b0;
        path_len     = 8'd0;
        entry_idx    = 5'd0;
        field_pos    = 8'd0;
        skip_pending = 1'b0;
        error_status = ST_RUNNING;
    endfunction

    function automatic logic [7:0] method_char(input logic [1:0] idx);
        return (idx == 2'd0) ? WORD_G : (idx == 2'd1) ? WORD_E : WORD_T;
    endfunction

    function automatic t_token tokenize_byte(input logic [7:0] b, input logic last);
        t_token r;
        logic   completed;
        r = '0;
        completed = 1'b0;
        case (phase)
            PH_METHOD: begin
                if (b == CH_SPACE) begin
                    if (get_seen) begin
                        phase      = PH_PATH;
                        field_pos  = 8'd0;
                        path_len   = 8'd0;
                        held_valid = 1'b0;
                    end else begin
                        phase        = PH_ERROR;
                        error_status = ST_BAD_METHOD;
                    end
                end else if (!get_seen) begin
                    if (b == method_char(get_count)) begin
                        get_count = get_count + 2'd1;
                        if (get_count == 2'd3) get_seen = 1'b1;
                    end else begin
                        phase        = PH_ERROR;
                        error_status = ST_BAD_METHOD;
                    end
                end
            end
            PH_PATH: begin
                if (b == CH_QUEST || b == CH_SPACE) begin
                    if (held_valid && !(held_char == CH_SLASH && path_len > 8'd1)) begin
                        r.cls = CLS_PATH;
                        r.ch  = held_char;
                        r.pos = field_pos;
                    end
                    held_valid = 1'b0;
                    phase      = (b == CH_QUEST) ? PH_PNAME : PH_LINESKIP;
                    field_pos  = 8'd0;
                    entry_idx  = 5'd0;
                end else begin
                    if (held_valid) begin
                        r.cls     = CLS_PATH;
                        r.ch      = held_char;
                        r.pos     = field_pos;
                        field_pos = bump8(field_pos);
                    end
                    held_char  = b;
                    held_valid = 1'b1;
                    path_len   = bump8(path_len);
                end
            end
            PH_PNAME: begin
                if (b == CH_EQUAL) begin
                    phase     = PH_PVALUE;
                    field_pos = 8'd0;
                end else begin
                    r.cls     = CLS_PNAME;
                    r.ch      = b;
                    r.item    = entry_idx[3:0];
                    r.pos     = field_pos;
                    field_pos = bump8(field_pos);
                end
            end
            PH_PVALUE: begin
                if (b == CH_AMP) begin
                    entry_idx = entry_idx + 5'd1;
                    field_pos = 8'd0;
                    phase     = (entry_idx >= PARAM_LIMIT_DEF) ? PH_LINESKIP : PH_PNAME;
                end else if (b == CH_SPACE) begin
                    phase = PH_LINESKIP;
                end else begin
                    r.cls     = CLS_PVALUE;
                    r.ch      = b;
                    r.item    = entry_idx[3:0];
                    r.pos     = field_pos;
                    field_pos = bump8(field_pos);
                end
            end
            PH_LINESKIP: begin
                if (b == CH_LF) begin
                    phase     = PH_HNAME;
                    entry_idx = 5'd0;
                    field_pos = 8'd0;
                end
            end
            PH_HNAME: begin
                if (field_pos == 8'd0 && b == CH_LF) begin
                    completed = 1'b1;
                end else if (field_pos == 8'd0 && b == CH_CR) begin
                    phase = PH_HTAIL;
                end else if (b == CH_COLON) begin
                    phase        = PH_HVALUE;
                    field_pos    = 8'd0;
                    skip_pending = 1'b1;
                end else begin
                    r.cls     = CLS_HNAME;
                    r.ch      = b;
                    r.item    = entry_idx[3:0];
                    r.pos     = field_pos;
                    field_pos = bump8(field_pos);
                end
            end
            PH_HVALUE: begin
                if (b == CH_LF) begin
                    entry_idx    = entry_idx + 5'd1;
                    field_pos    = 8'd0;
                    skip_pending = 1'b0;
                    phase        = (entry_idx >= HEADER_LIMIT_DEF) ? PH_HTAIL : PH_HNAME;
                end else if (skip_pending) begin
                    skip_pending = 1'b0;
                end else begin
                    r.cls     = CLS_HVALUE;
                    r.ch      = b;
                    r.item    = entry_idx[3:0];
                    r.pos     = field_pos;
                    field_pos = bump8(field_pos);
                end
            end
            PH_HTAIL: begin
                if (b == CH_LF) completed = 1'b1;
            end
            default: ;
        endcase

        if (completed) begin
            phase        = PH_DONE;
            error_status = ST_COMPLETE;
            r.status     = ST_COMPLETE;
            r.done       = 1'b1;
        end else if (last) begin
            case (phase)
                PH_METHOD:                         r.status = ST_BAD_METHOD;
                PH_PATH:                           r.status = ST_BAD_PATH;
                PH_PNAME, PH_PVALUE, PH_LINESKIP:  r.status = ST_BAD_PARAMS;
                PH_HNAME, PH_HVALUE, PH_HTAIL:     r.status = ST_BAD_HEADERS;
                PH_ERROR:                          r.status = error_status;
                default: ;
            endcase
            r.done = (phase != PH_DONE);
        end

        if (last) clear_parser();
        return r;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic last, input logic typed,
                                    input logic [2:0] status, input logic done);
        t_table_row row;
        row.b      = b;
        row.last   = last;
        row.typed  = typed;
        row.status = status;
        row.done   = done;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [7:0] pick_char(input logic [7:0] x0, input logic [7:0] x1,
                                             input logic [7:0] x2);
        logic [7:0] c;
        c = x0;
        while (c == x0 || c == x1 || c == x2) begin
            if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
            else c = 8'($urandom_range(8'h61, 8'h7A));
        end
        return c;
    endfunction

    function automatic int field_len();
        return ($urandom_range(0, 149) == 0) ? $urandom_range(250, 262) : $urandom_range(0, 6);
    endfunction

    function automatic void push_field(input int n, input logic [7:0] x0, input logic [7:0] x1,
                                       input logic [7:0] x2);
        for (int i = 0; i < n; i++) request_bytes.push_back(pick_char(x0, x1, x2));
    endfunction

    function automatic void build_request();
        int kind;
        int count;
        request_bytes.delete();
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
            count = $urandom_range(1, 6);
            for (int i = 0; i < count; i++) request_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        request_bytes.push_back(WORD_G);
        if (kind == 1) begin
            request_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            request_bytes.push_back(WORD_E);
        end
        if (kind == 1 && $urandom_range(0, 1) == 0) request_bytes.push_back(CH_SPACE);
        request_bytes.push_back(WORD_T);
        if ($urandom_range(0, 7) == 0) begin
            request_bytes.push_back(pick_char(CH_SPACE, CH_SPACE, CH_SPACE));
        end
        request_bytes.push_back(CH_SPACE);

        request_bytes.push_back(($urandom_range(0, 7) == 0)
                                ? pick_char(CH_QUEST, CH_SPACE, CH_SLASH) : CH_SLASH);
        count = field_len();
        for (int i = 0; i < count; i++) begin
            request_bytes.push_back(($urandom_range(0, 4) == 0) ? CH_SLASH
                                    : pick_char(CH_QUEST, CH_SPACE, CH_SLASH));
        end
        if ($urandom_range(0, 2) == 0) request_bytes.push_back(CH_SLASH);

        if ($urandom_range(0, 1) == 0) begin
            request_bytes.push_back(CH_QUEST);
            count = $urandom_range(0, 10);
            for (int p = 0; p < count; p++) begin
                push_field(field_len(), CH_EQUAL, CH_SPACE, CH_AMP);
                request_bytes.push_back(CH_EQUAL);
                push_field(field_len(), CH_AMP, CH_SPACE, CH_LF);
                if (p < count - 1) request_bytes.push_back(CH_AMP);
            end
        end
        request_bytes.push_back(CH_SPACE);
        push_field(field_len(), CH_LF, CH_LF, CH_LF);
        request_bytes.push_back(CH_CR);
        request_bytes.push_back(CH_LF);

        count = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 3);
        for (int h = 0; h < count; h++) begin
            push_field((field_len() == 0) ? 1 : field_len(), CH_COLON, CH_CR, CH_LF);
            request_bytes.push_back(CH_COLON);
            if ($urandom_range(0, 5) == 0) begin
                request_bytes.push_back(CH_LF);
            end else begin
                request_bytes.push_back(CH_SPACE);
                push_field(field_len(), CH_LF, CH_LF, CH_LF);
                request_bytes.push_back(CH_CR);
                request_bytes.push_back(CH_LF);
            end
        end
        if ($urandom_range(0, 1) == 0) request_bytes.push_back(CH_CR);
        request_bytes.push_back(CH_LF);
        if ($urandom_range(0, 3) == 0) begin
            count = $urandom_range(1, 3);
            for (int i = 0; i < count; i++) request_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (kind == 2) begin
            count = $urandom_range(1, request_bytes.size());
            while (request_bytes.size() > count) void'(request_bytes.pop_back());
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input logic [2:0] status, input logic done);
        int     gap;
        t_token want;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_in_byte   <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        want = tokenize_byte(b, last);
        if (typed) begin
            want        = '0;
            want.status = status;
            want.done   = done;
        end
        expected_tokens.push_back(want);
        bytes_sent++;
    endtask

    task automatic compare_field(input string label, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin : result_sink
        int     gap;
        t_token want;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual class %0d char %0d",
                         $time, o_field_class, o_out_char);
                mismatches++;
            end else begin
                want = expected_tokens.pop_front();
                compare_field("field_class", {5'd0, want.cls}, {5'd0, o_field_class});
                compare_field("out_char", want.ch, o_out_char);
                compare_field("item_number", {4'd0, want.item}, {4'd0, o_item_number});
                compare_field("char_position", want.pos, o_char_position);
                compare_field("parse_status", {5'd0, want.status}, {5'd0, o_parse_status});
                compare_field("request_done", {7'd0, want.done}, {7'd0, o_request_done});
            end
        end
    end

    initial begin : byte_source
        bytes_sent   = 0;
        steady       = 1'b0;
        clear_parser();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_in_byte   <= 8'd0;
        i_last_byte <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row("X",      1'b0, 1'b1, ST_RUNNING,    1'b0);
        add_row(8'hFF,    1'b1, 1'b1, ST_BAD_METHOD, 1'b1);
        add_row("G",      1'b1, 1'b1, ST_BAD_METHOD, 1'b1);
        add_row("G",      1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row("E",      1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row("T",      1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row(CH_SPACE, 1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row(CH_SLASH, 1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row("a",      1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row(CH_SLASH, 1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row(CH_QUEST, 1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row("k",      1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row(CH_EQUAL, 1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row("v",      1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row(CH_SPACE, 1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row("X",      1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row(CH_LF,    1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row("H",      1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row(CH_COLON, 1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row(CH_SPACE, 1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row("z",      1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row(CH_LF,    1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row(CH_CR,    1'b0, 1'b0, ST_RUNNING,    1'b0);
        add_row(CH_LF,    1'b0, 1'b1, ST_COMPLETE,   1'b1);
        add_row(8'h00,    1'b1, 1'b1, ST_RUNNING,    1'b0);
        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].status, directed_rows[i].done);
        end

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            steady = ($urandom_range(0, 3) == 0);
            build_request();
            foreach (request_bytes[i]) begin
                send_byte(request_bytes[i], i == request_bytes.size() - 1, 1'b0,
                          ST_RUNNING, 1'b0);
            end
        end

        i_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/htok_pkg.sv
hw/rtl/http_request_tokenizer.sv
dv/testbench.sv
